FILE: rtl/fixed_point_alu_unit_defines.svh
// Assertion macros shared by the fixed-point ALU files.
`ifndef FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("fixed_point_alu_unit: assertion failed");
`define FPA_NEVER(lbl, clk_s, rstn_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error("fixed_point_alu_unit: forbidden condition seen");
`else
`define FPA_ASSERT(lbl, clk_s, rstn_s, prop)
`define FPA_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

FILE: rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int MODE_W        = 4;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int IN_DATA_W     = 2 * DATA_W;
  localparam int OUT_ITEM_W    = DATA_W + 4;
  localparam int OUT_DATA_W    = ((OUT_ITEM_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_DATA_W - OUT_ITEM_W;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_MIN = 4'd4,
    MODE_MAX = 4'd5,
    MODE_INC = 4'd6,
    MODE_DEC = 4'd7,
    MODE_I2F = 4'd8,
    MODE_F2I = 4'd9,
    MODE_CMP = 4'd10
  } mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] other;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
    logic              is_div;
    logic              neg;
  } alu_tag_t;

  typedef struct packed {
    logic              div_zero;
    logic              a_greater;
    logic              a_equal;
    logic              a_less;
    logic [DATA_W-1:0] result;
  } out_item_t;

endpackage

FILE: rtl/fixed_point_alu_unit.sv
// Path: registers s0 and s1, 32 + FRAC_BITS divider subtract stages, output register.
// Throughput: one item per cycle while the pipeline is not halted.
// The whole pipeline advances together and halts only while the output skid register is full.
// Reset is synchronous and active low; it clears all valid bits, including the output stage's.
`include "fixed_point_alu_unit_defines.svh"

module fixed_point_alu_unit
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [MODE_W-1:0]     in_tuser,   // mode[3:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // result[31:0], a_less[32], a_equal[33],
                                            // a_greater[34], div_zero[35], zero[39:36]
);

  logic                        en;
  logic                        fr_vld;
  logic [DATA_W+FRAC_BITS-1:0] fr_dvd;
  logic [DATA_W-1:0]           fr_dsr;
  alu_tag_t                    fr_tag;
  logic                        dv_vld;
  logic [DATA_W-1:0]           dv_quo;
  alu_tag_t                    dv_tag;
  logic [DATA_W-1:0]           quo_signed;
  out_item_t                   fin_item;
  out_item_t                   out_item;

  assign in_tready = en;

  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_mode (in_tuser),
    .in_a    (in_tdata[DATA_W-1:0]),
    .in_b    (in_tdata[IN_DATA_W-1:DATA_W]),
    .out_vld (fr_vld),
    .out_dvd (fr_dvd),
    .out_dsr (fr_dsr),
    .out_tag (fr_tag)
  );

  fpa_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (fr_vld),
    .in_dvd  (fr_dvd),
    .in_dsr  (fr_dsr),
    .in_tag  (fr_tag),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_tag (dv_tag)
  );

  assign quo_signed         = dv_tag.neg ? DATA_W'(-dv_quo) : dv_quo;
  assign fin_item.result    = dv_tag.is_div ? quo_signed : dv_tag.other;
  assign fin_item.a_less    = dv_tag.lt;
  assign fin_item.a_equal   = dv_tag.eq;
  assign fin_item.a_greater = dv_tag.gt;
  assign fin_item.div_zero  = dv_tag.dz;

  fpa_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (dv_vld),
    .in_rdy   (en),
    .in_item  (fin_item),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_item (out_item)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_item};

  `FPA_ASSERT(a_one_cmp_flag, clk, rst_n,
              out_tvalid |-> $onehot({out_item.a_less, out_item.a_equal, out_item.a_greater}))
  `FPA_ASSERT(a_dz_gives_zero, clk, rst_n,
              (out_tvalid && out_item.div_zero) |-> (out_item.result == '0))
  `FPA_NEVER(a_dz_is_not_div, clk, rst_n, dv_vld && dv_tag.dz && dv_tag.is_div)

endmodule

FILE: rtl/fpa_front.sv
module fpa_front
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [MODE_W-1:0]             in_mode,
  input  logic signed [DATA_W-1:0]      in_a,
  input  logic signed [DATA_W-1:0]      in_b,
  output logic                          out_vld,
  output logic [DATA_W+FRAC_BITS-1:0]   out_dvd,
  output logic [DATA_W-1:0]             out_dsr,
  output alu_tag_t                      out_tag
);

  logic                     s0_vld_r;
  logic [MODE_W-1:0]        s0_mode_r;
  logic signed [DATA_W-1:0] s0_a_r;
  logic signed [DATA_W-1:0] s0_b_r;

  logic                     lt;
  logic                     eq;
  logic                     gt;
  logic signed [DATA_W-1:0] simple;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [DATA_W-1:0]        ma;
  logic [DATA_W-1:0]        mb;

  logic                     s1_vld_r;
  logic signed [PROD_W-1:0] s1_prod_r;
  logic signed [DATA_W-1:0] s1_simple_r;
  logic                     s1_is_mul_r;
  logic                     s1_lt_r;
  logic                     s1_eq_r;
  logic                     s1_gt_r;
  logic                     s1_dz_r;
  logic                     s1_is_div_r;
  logic                     s1_neg_r;
  logic [DATA_W-1:0]        s1_ma_r;
  logic [DATA_W-1:0]        s1_mb_r;
  logic signed [PROD_W-1:0] prod_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_vld;
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mode_r <= in_mode;
      s0_a_r    <= in_a;
      s0_b_r    <= in_b;
    end
  end

  assign lt       = s0_a_r < s0_b_r;
  assign eq       = s0_a_r == s0_b_r;
  assign gt       = s0_a_r > s0_b_r;
  assign prod_nxt = s0_a_r * s0_b_r;
  assign ma       = s0_a_r[DATA_W-1] ? DATA_W'(-s0_a_r) : DATA_W'(s0_a_r);
  assign mb       = s0_b_r[DATA_W-1] ? DATA_W'(-s0_b_r) : DATA_W'(s0_b_r);

  always_comb begin
    case (s0_mode_r)
      MODE_ADD: simple = s0_a_r + s0_b_r;
      MODE_SUB: simple = s0_a_r - s0_b_r;
      MODE_MIN: simple = lt ? s0_a_r : s0_b_r;
      MODE_MAX: simple = gt ? s0_a_r : s0_b_r;
      MODE_INC: simple = s0_a_r + DATA_W'(1);
      MODE_DEC: simple = s0_a_r - DATA_W'(1);
      MODE_I2F: simple = s0_a_r <<< FRAC_BITS;
      MODE_F2I: simple = s0_a_r >>> FRAC_BITS;
      MODE_MUL, MODE_DIV, MODE_CMP: simple = '0;
      default:  simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r   <= prod_nxt;
      s1_simple_r <= simple;
      s1_is_mul_r <= s0_mode_r == MODE_MUL;
      s1_lt_r     <= lt;
      s1_eq_r     <= eq;
      s1_gt_r     <= gt;
      s1_dz_r     <= (s0_mode_r == MODE_DIV) && (s0_b_r == '0);
      s1_is_div_r <= (s0_mode_r == MODE_DIV) && (s0_b_r != '0);
      s1_neg_r    <= s0_a_r[DATA_W-1] != s0_b_r[DATA_W-1];
      s1_ma_r     <= ma;
      s1_mb_r     <= mb;
    end
  end

  assign prod_sh        = s1_prod_r >>> FRAC_BITS;
  assign out_vld        = s1_vld_r;
  assign out_dvd        = {s1_ma_r, {FRAC_BITS{1'b0}}};
  assign out_dsr        = s1_mb_r;
  assign out_tag.other  = s1_is_mul_r ? prod_sh[DATA_W-1:0] : s1_simple_r;
  assign out_tag.lt     = s1_lt_r;
  assign out_tag.eq     = s1_eq_r;
  assign out_tag.gt     = s1_gt_r;
  assign out_tag.dz     = s1_dz_r;
  assign out_tag.is_div = s1_is_div_r;
  assign out_tag.neg    = s1_neg_r;

endmodule

FILE: rtl/fpa_div_pipe.sv
`include "fixed_point_alu_unit_defines.svh"

module fpa_div_pipe
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [DATA_W+FRAC_BITS-1:0] in_dvd,
  input  logic [DATA_W-1:0]           in_dsr,
  input  alu_tag_t                    in_tag,
  output logic                        out_vld,
  output logic [DATA_W-1:0]           out_quo,
  output alu_tag_t                    out_tag
);

  localparam int DVD_W  = DATA_W + FRAC_BITS;
  localparam int STAGES = DVD_W;

  // One restoring step per stage, quotient bits from the top down.
  logic              vld_r [STAGES];
  logic [DATA_W-1:0] rem_r [STAGES];
  logic [DVD_W-1:0]  dvd_r [STAGES];
  logic [DATA_W-1:0] quo_r [STAGES];
  logic [DATA_W-1:0] dsr_r [STAGES];
  alu_tag_t          tag_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic              vld_in;
    logic [DATA_W-1:0] rem_in;
    logic [DVD_W-1:0]  dvd_in;
    logic [DATA_W-1:0] quo_in;
    logic [DATA_W-1:0] dsr_in;
    alu_tag_t          tag_in;
    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;
    logic              take;

    if (k == 0) begin : g_head
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign dvd_in = in_dvd;
      assign quo_in = '0;
      assign dsr_in = in_dsr;
      assign tag_in = in_tag;
    end else begin : g_body
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign dvd_in = dvd_r[k-1];
      assign quo_in = quo_r[k-1];
      assign dsr_in = dsr_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    assign trial = {rem_in, dvd_in[DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_in};
    assign take  = !diff[DATA_W+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        dvd_r[k] <= {dvd_in[DVD_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[DATA_W-2:0], take};
        dsr_r[k] <= dsr_in;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_quo = quo_r[STAGES-1];
  assign out_tag = tag_r[STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_chk
    `FPA_ASSERT(a_rem_below_dsr, clk, rst_n, (vld_r[k] && (dsr_r[k] != '0)) |-> (rem_r[k] < dsr_r[k]))
  end

endmodule

FILE: rtl/fpa_skid.sv
`include "fixed_point_alu_unit_defines.svh"

module fpa_skid
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  output logic      in_rdy,
  input  out_item_t in_item,
  output logic      out_vld,
  input  logic      out_rdy,
  output out_item_t out_item
);

  logic      out_vld_r;
  logic      out_vld_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      skid_vld_r;
  logic      skid_vld_nxt;
  out_item_t skid_item_r;
  out_item_t skid_item_nxt;

  assign in_rdy = !skid_vld_r;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_item_nxt  = out_item_r;
    skid_vld_nxt  = skid_vld_r;
    skid_item_nxt = skid_item_r;
    if (!out_vld_r || out_rdy) begin
      out_vld_nxt  = skid_vld_r || in_vld;
      out_item_nxt = skid_vld_r ? skid_item_r : in_item;
      skid_vld_nxt = 1'b0;
    end else if (!skid_vld_r && in_vld) begin
      skid_vld_nxt  = 1'b1;
      skid_item_nxt = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

  `FPA_NEVER(a_skid_only_behind_out, clk, rst_n, skid_vld_r && !out_vld_r)

endmodule

FILE: tb/fixed_point_alu_unit_test.sv
module fixed_point_alu_unit_test;
  import fpa_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int LATENCY     = 34 + FRAC;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT = 150000;
  localparam int REPORT_MAX  = 10;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_pattern_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    bit                known;
    out_item_t         res;
  } alu_op_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // operand_a[31:0], operand_b[63:32]
  logic [MODE_W-1:0]     in_tuser;   // mode[3:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // result[31:0], a_less[32], a_equal[33],
                                     // a_greater[34], div_zero[35], zero[39:36]

  out_item_t pending_results[$];
  alu_op_t   op_list[$];
  int        error_count = 0;
  int        cycle_count = 0;

  fixed_point_alu_unit #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic out_item_t alu_compute(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] a,
                                            logic [DATA_W-1:0] b);
    out_item_t          r;
    logic signed [63:0] wide;
    logic signed [63:0] divisor;
    r = '0;
    r.a_less    = $signed(a) < $signed(b);
    r.a_equal   = a == b;
    r.a_greater = $signed(a) > $signed(b);
    case (mode)
      MODE_ADD: r.result = a + b;
      MODE_SUB: r.result = a - b;
      MODE_MUL: begin
        wide = 64'($signed(a)) * 64'($signed(b));
        wide = wide >>> FRAC;
        r.result = wide[DATA_W-1:0];
      end
      MODE_DIV: begin
        if (b == '0) begin
          r.div_zero = 1'b1;
        end else begin
          wide = 64'($signed(a));
          wide = wide <<< FRAC;
          divisor = 64'($signed(b));
          wide = wide / divisor;
          r.result = wide[DATA_W-1:0];
        end
      end
      MODE_MIN: r.result = r.a_less ? a : b;
      MODE_MAX: r.result = r.a_greater ? a : b;
      MODE_INC: r.result = a + 1;
      MODE_DEC: r.result = a - 1;
      MODE_I2F: r.result = a << FRAC;
      MODE_F2I: r.result = $signed(a) >>> FRAC;
      default:  r.result = '0;
    endcase
    return r;
  endfunction

  function automatic alu_op_t alu_op(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] a,
                                     logic [DATA_W-1:0] b, bit known, logic [DATA_W-1:0] res,
                                     logic lt, logic eq, logic gt, logic dz);
    alu_op_t op;
    op.mode          = mode;
    op.a             = a;
    op.b             = b;
    op.known         = known;
    op.res.result    = res;
    op.res.a_less    = lt;
    op.res.a_equal   = eq;
    op.res.a_greater = gt;
    op.res.div_zero  = dz;
    return op;
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          default: v = 32'hffff_ffff;
        endcase
      end
      1, 2: v = $urandom_range(0, 1023) - 512;
      3, 4: v = ($urandom_range(0, 4095) - 2048) << FRAC;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fixed_point_alu_unit: mismatch");
      $finish;
    end
  end

  initial begin
    ready_pattern_t pattern;
    int             phase_left;
    pattern    = READY_ALWAYS;
    phase_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        pattern    = ready_pattern_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      case (pattern)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:      out_tready <= (phase_left % 5) < 2;
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_ITEM_W-1:0];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX) begin
          $display("unexpected result item: result=%h lt=%b eq=%b gt=%b dz=%b",
                   got.result, got.a_less, got.a_equal, got.a_greater, got.div_zero);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.result !== want.result || got.a_less !== want.a_less ||
            got.a_equal !== want.a_equal || got.a_greater !== want.a_greater ||
            got.div_zero !== want.div_zero) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("result item differs: expected result=%h lt=%b eq=%b gt=%b dz=%b",
                     want.result, want.a_less, want.a_equal, want.a_greater, want.div_zero);
            $display("                     actual   result=%h lt=%b eq=%b gt=%b dz=%b",
                     got.result, got.a_less, got.a_equal, got.a_greater, got.div_zero);
          end
        end
      end
    end
  end

  initial begin
    int                burst_left;
    int                gap;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    burst_left  = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;

    op_list.push_back(alu_op(MODE_ADD, 32'h0000_0000, 32'h0000_0000, 1, 32'h0, 0, 1, 0, 0));
    op_list.push_back(alu_op(MODE_ADD, 32'h7fff_ffff, 32'h0000_0001, 1, 32'h8000_0000,
                             0, 0, 1, 0));
    op_list.push_back(alu_op(MODE_SUB, 32'h8000_0000, 32'h0000_0001, 1, 32'h7fff_ffff,
                             1, 0, 0, 0));
    op_list.push_back(alu_op(MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_MUL, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_MUL, 32'h0000_0100, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_DIV, 32'h0000_0005, 32'h0000_0000, 1, 32'h0, 0, 0, 1, 1));
    op_list.push_back(alu_op(MODE_DIV, 32'h8000_0000, 32'h0000_0000, 1, 32'h0, 1, 0, 0, 1));
    op_list.push_back(alu_op(MODE_DIV, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_DIV, 32'h7fff_ffff, 32'h0000_0001, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_DIV, 32'hffff_fd00, 32'h0000_0200, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_MIN, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0000,
                             1, 0, 0, 0));
    op_list.push_back(alu_op(MODE_MAX, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h7fff_ffff,
                             1, 0, 0, 0));
    op_list.push_back(alu_op(MODE_MIN, 32'h0000_0007, 32'h0000_0007, 1, 32'h7, 0, 1, 0, 0));
    op_list.push_back(alu_op(MODE_INC, 32'h7fff_ffff, 32'h0000_0000, 1, 32'h8000_0000,
                             0, 0, 1, 0));
    op_list.push_back(alu_op(MODE_DEC, 32'h8000_0000, 32'h0000_0000, 1, 32'h7fff_ffff,
                             1, 0, 0, 0));
    op_list.push_back(alu_op(MODE_I2F, 32'h7fff_ffff, 32'h0000_0000, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_I2F, 32'hffff_ffff, 32'h0000_0000, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_F2I, 32'h8000_0000, 32'h0000_0000, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_F2I, 32'h0000_00ff, 32'h0000_0000, 0, 0, 0, 0, 0, 0));
    op_list.push_back(alu_op(MODE_CMP, 32'hffff_ffff, 32'h0000_0001, 1, 32'h0, 1, 0, 0, 0));
    op_list.push_back(alu_op(MODE_CMP, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h0, 0, 0, 1, 0));
    op_list.push_back(alu_op(4'd11, 32'h0000_0003, 32'h0000_0003, 1, 32'h0, 0, 1, 0, 0));
    op_list.push_back(alu_op(4'd15, 32'hffff_fffb, 32'h0000_0002, 1, 32'h0, 1, 0, 0, 0));

    // Random items lean toward small and extreme operands, with zero and equal divisors.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        mode = MODE_W'($urandom_range(11, 15));
      end else begin
        mode = MODE_W'($urandom_range(0, 10));
      end
      a = pick_operand();
      case ($urandom_range(0, 7))
        0: b = '0;
        1: b = a;
        default: b = pick_operand();
      endcase
      op_list.push_back(alu_op(mode, a, b, 0, 0, 0, 0, 0, 0));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (op_list[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      in_tvalid <= 1'b1;
      in_tdata  <= {op_list[i].b, op_list[i].a};
      in_tuser  <= op_list[i].mode;
      do @(posedge clk); while (!in_tready);
      if (op_list[i].known) begin
        pending_results.push_back(op_list[i].res);
      end else begin
        pending_results.push_back(alu_compute(op_list[i].mode, op_list[i].a, op_list[i].b));
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("fixed_point_alu_unit: match");
    end else begin
      $display("fixed_point_alu_unit: mismatch");
    end
    $finish;
  end

endmodule
